>>> sv/bpa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and constants for the buddy page allocator
// Pool geometry, widths, status and request codes, node result, round_pow2.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // Pool geometry
  localparam int POOL_PAGES = 1024;
  localparam int LEVELS     = $clog2(POOL_PAGES);
  localparam int NODES      = 2 * POOL_PAGES - 1;
  localparam int IDX_W      = $clog2(NODES);
  localparam int VAL_W      = LEVELS + 1;

  // Field widths
  localparam int OFF_W       = 10;
  localparam int PAGES_W     = 11;
  localparam int RND_W       = PAGES_W + 1;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 2'd3;

  // Request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Node unit result
  typedef struct packed {
    logic [VAL_W-1:0] merge;    // new parent value
    logic             ge_n;     // node value covers the request
    logic             is_zero;  // node fully allocated
  } node_res_t;

  // Smallest power of two not below n (independent compares, smallest wins)
  function automatic logic [RND_W-1:0] round_pow2(input logic [PAGES_W-1:0] n);
    logic [RND_W-1:0] r;
    r = RND_W'(1) << (RND_W - 1);
    for (int k = RND_W - 1; k >= 0; k--) begin
      if ((RND_W'(1) << k) >= RND_W'(n)) begin
        r = RND_W'(1) << k;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/bpa_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> sv/bpa_node_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_node_unit: shared compare and merge unit for tree nodes
// Compares a node value against the request size and merges two children.
// ----------------------------------------------------------------------------
module bpa_node_unit (
  input  wire logic                      free_mode,
  input  wire logic [bpa_pkg::VAL_W-1:0] node_val,  // value read from the tree
  input  wire logic [bpa_pkg::VAL_W-1:0] child_val, // freshly written child
  input  wire logic [bpa_pkg::VAL_W-1:0] req_size,
  input  wire logic [bpa_pkg::VAL_W-1:0] par_size,  // subtree size of parent
  output      bpa_pkg::node_res_t        res
);

  logic [bpa_pkg::VAL_W:0]   sum;
  logic [bpa_pkg::VAL_W-1:0] larger;

  // Larger child and buddy sum
  assign larger = (node_val > child_val) ? node_val : child_val;
  assign sum    = {1'b0, node_val} + {1'b0, child_val};

  // Free merges two whole buddies into one block
  always_comb begin
    res.merge = larger;
    if (free_mode && (sum == {1'b0, par_size})) begin
      res.merge = par_size;
    end
    res.ge_n    = (node_val >= req_size);
    res.is_zero = (node_val == '0);
  end

endmodule
`default_nettype wire

>>> sv/buddy_page_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_page_allocator_unit: buddy page allocator over a 1024-page pool
// Allocate walks down from the root to the block, then refreshes its ancestors;
//   free climbs from the leaf to the allocated block, then merges buddies up to
//   the root; entry errors are reported without touching the tree.
// Requests are taken one at a time: in_tready stays low until the result is handed off.
// Reset: rst_n clears control, then a pass over every tree node rebuilds the tree with
//   in_tready low.
// ----------------------------------------------------------------------------
module buddy_page_allocator_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output      logic                                in_tready,
  input  wire logic [bpa_pkg::IN_TDATA_W-1:0]      in_tdata,  // request_pages, block_offset
  input  wire logic                                in_tuser,  // req_type
  output      logic                                out_tvalid,
  input  wire logic                                out_tready,
  output      logic [bpa_pkg::OUT_TDATA_W-1:0]     out_tdata, // granted_offset, granted_pages,
                                                              // largest_free
  output      logic [bpa_pkg::STATUS_W-1:0]        out_tuser  // status
);

  localparam int IDX_W = bpa_pkg::IDX_W;
  localparam int VAL_W = bpa_pkg::VAL_W;
  localparam int OFF_W = bpa_pkg::OFF_W;

  // Sequencer states
  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DN_RD  = 4'd2;
  localparam logic [3:0] S_DN_CHK = 4'd3;
  localparam logic [3:0] S_FR_RD  = 4'd4;
  localparam logic [3:0] S_FR_CHK = 4'd5;
  localparam logic [3:0] S_MARK   = 4'd6;
  localparam logic [3:0] S_UP_RD  = 4'd7;
  localparam logic [3:0] S_UP_WR  = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  localparam logic [VAL_W-1:0] POOL_V = VAL_W'(bpa_pkg::POOL_PAGES);

  logic [3:0]                  state_r, state_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic [VAL_W-1:0]            nsz_r, nsz_nxt;
  logic [VAL_W-1:0]            n_r, n_nxt;
  logic [OFF_W-1:0]            off_r, off_nxt;
  logic [VAL_W-1:0]            cval_r, cval_nxt;
  logic                        typ_r, typ_nxt;
  logic [bpa_pkg::STATUS_W-1:0] st_r, st_nxt;
  logic [VAL_W-1:0]            gp_r, gp_nxt;
  logic [VAL_W-1:0]            root_r, root_nxt;

  logic                        ov_r, ov_nxt;
  logic [bpa_pkg::STATUS_W-1:0] ost_r, ost_nxt;
  logic [OFF_W-1:0]            ooff_r, ooff_nxt;
  logic [VAL_W-1:0]            opg_r, opg_nxt;
  logic [VAL_W-1:0]            olf_r, olf_nxt;

  logic                        ram_we, ram_re;
  logic [IDX_W-1:0]            ram_waddr, ram_raddr;
  logic [VAL_W-1:0]            ram_wdata, ram_rdata;

  bpa_pkg::node_res_t          nres;

  logic [bpa_pkg::PAGES_W-1:0] in_req;
  logic [OFF_W-1:0]            in_off;
  logic [bpa_pkg::RND_W-1:0]   req_rnd;
  logic                        in_fire;
  logic [IDX_W-1:0]            left_idx, par_idx, sib_idx, clr_next, clr_next1;
  logic [VAL_W-1:0]            child_sz, par_sz, nsz_mask;

  // Input unpacking
  assign in_req  = in_tdata[bpa_pkg::PAGES_W-1:0];
  assign in_off  = in_tdata[bpa_pkg::PAGES_W +: OFF_W];
  assign req_rnd = bpa_pkg::round_pow2(in_req);
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // Tree index arithmetic
  assign left_idx  = {idx_r[IDX_W-2:0], 1'b1};
  assign par_idx   = (idx_r - IDX_W'(1)) >> 1;
  assign sib_idx   = idx_r[0] ? (idx_r + IDX_W'(1)) : (idx_r - IDX_W'(1));
  assign child_sz  = nsz_r >> 1;
  assign par_sz    = nsz_r << 1;
  assign nsz_mask  = nsz_r - VAL_W'(1);
  assign clr_next  = idx_r + IDX_W'(1);
  assign clr_next1 = clr_next + IDX_W'(1);

  // Tree storage
  bpa_ram #(
    .WIDTH (VAL_W),
    .DEPTH (bpa_pkg::NODES)
  ) u_tree (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared compare and merge unit
  bpa_node_unit u_node (
    .free_mode (typ_r == bpa_pkg::REQ_FREE),
    .node_val  (ram_rdata),
    .child_val (cval_r),
    .req_size  (n_r),
    .par_size  (par_sz),
    .res       (nres)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    nsz_nxt   = nsz_r;
    n_nxt     = n_r;
    off_nxt   = off_r;
    cval_nxt  = cval_r;
    typ_nxt   = typ_r;
    st_nxt    = st_r;
    gp_nxt    = gp_r;
    root_nxt  = root_r;
    ov_nxt    = ov_r && !out_tready;
    ost_nxt   = ost_r;
    ooff_nxt  = ooff_r;
    opg_nxt   = opg_r;
    olf_nxt   = olf_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = cval_r;
    ram_re    = 1'b0;
    ram_raddr = idx_r;

    case (state_r)
      // Rebuild the tree: each node holds its subtree size
      S_CLR: begin
        ram_we    = 1'b1;
        ram_wdata = nsz_r;
        if (idx_r == IDX_W'(bpa_pkg::NODES - 1)) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = clr_next;
          if ((clr_next1 & clr_next) == '0) begin
            nsz_nxt = child_sz;
          end
        end
      end

      // Take a request and screen it
      S_IDLE: begin
        if (in_fire) begin
          typ_nxt  = in_tuser;
          st_nxt   = bpa_pkg::ST_OK;
          gp_nxt   = '0;
          cval_nxt = '0;
          n_nxt    = req_rnd[VAL_W-1:0];
          if (in_tuser == bpa_pkg::REQ_ALLOC) begin
            idx_nxt = '0;
            nsz_nxt = POOL_V;
            off_nxt = '0;
            if (in_req == '0) begin
              st_nxt    = bpa_pkg::ST_BAD_SIZE;
              state_nxt = S_DONE;
            end else if (in_req > root_r) begin
              st_nxt    = bpa_pkg::ST_NO_SPACE;
              state_nxt = S_DONE;
            end else if (req_rnd == bpa_pkg::RND_W'(bpa_pkg::POOL_PAGES)) begin
              state_nxt = S_MARK;
            end else begin
              state_nxt = S_DN_RD;
            end
          end else begin
            idx_nxt = IDX_W'(in_off) + IDX_W'(bpa_pkg::POOL_PAGES - 1);
            nsz_nxt = VAL_W'(1);
            off_nxt = in_off;
            if (in_req == '0) begin
              st_nxt    = bpa_pkg::ST_BAD_SIZE;
              state_nxt = S_DONE;
            end else if (req_rnd > bpa_pkg::RND_W'(bpa_pkg::POOL_PAGES)) begin
              st_nxt    = bpa_pkg::ST_BAD_SIZE;
              state_nxt = S_DONE;
            end else if (32'(in_off) >= 32'(bpa_pkg::POOL_PAGES)) begin
              st_nxt    = bpa_pkg::ST_BAD_FREE;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_FR_RD;
            end
          end
        end
      end

      // Allocate walk down: read the left child
      S_DN_RD: begin
        ram_re    = 1'b1;
        ram_raddr = left_idx;
        state_nxt = S_DN_CHK;
      end

      // Prefer the left child when it can hold the block
      S_DN_CHK: begin
        nsz_nxt = child_sz;
        if (nres.ge_n) begin
          idx_nxt = left_idx;
        end else begin
          idx_nxt = left_idx + IDX_W'(1);
          off_nxt = off_r + child_sz[OFF_W-1:0];
        end
        state_nxt = (child_sz == n_r) ? S_MARK : S_DN_RD;
      end

      // Free climb: read the current node
      S_FR_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_FR_CHK;
      end

      // Stop at the first allocated node, then check start and size
      S_FR_CHK: begin
        if (!nres.is_zero) begin
          if (idx_r == '0) begin
            st_nxt    = bpa_pkg::ST_BAD_FREE;
            state_nxt = S_DONE;
          end else begin
            nsz_nxt   = par_sz;
            idx_nxt   = par_idx;
            state_nxt = S_FR_RD;
          end
        end else if ((off_r & nsz_mask[OFF_W-1:0]) != '0) begin
          st_nxt    = bpa_pkg::ST_BAD_FREE;
          state_nxt = S_DONE;
        end else if (nsz_r != n_r) begin
          st_nxt    = bpa_pkg::ST_BAD_SIZE;
          state_nxt = S_DONE;
        end else begin
          cval_nxt  = nsz_r;
          state_nxt = S_MARK;
        end
      end

      // Write the block node: zero on allocate, full size on free
      S_MARK: begin
        ram_we = 1'b1;
        gp_nxt = nsz_r;
        if (idx_r == '0) begin
          root_nxt  = cval_r;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_UP_RD;
        end
      end

      // Ancestor refresh: read the buddy
      S_UP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = sib_idx;
        state_nxt = S_UP_WR;
      end

      // Write the merged parent
      S_UP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = par_idx;
        ram_wdata = nres.merge;
        cval_nxt  = nres.merge;
        nsz_nxt   = par_sz;
        idx_nxt   = par_idx;
        if (par_idx == '0) begin
          root_nxt  = nres.merge;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_UP_RD;
        end
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          ost_nxt   = st_r;
          ooff_nxt  = '0;
          opg_nxt   = '0;
          olf_nxt   = root_r;
          if (st_r == bpa_pkg::ST_OK) begin
            opg_nxt = gp_r;
            if (typ_r == bpa_pkg::REQ_ALLOC) begin
              ooff_nxt = off_r;
            end
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      idx_r   <= '0;
      nsz_r   <= POOL_V;
      root_r  <= POOL_V;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      nsz_r   <= nsz_nxt;
      root_r  <= root_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    off_r  <= off_nxt;
    cval_r <= cval_nxt;
    typ_r  <= typ_nxt;
    st_r   <= st_nxt;
    gp_r   <= gp_nxt;
    ost_r  <= ost_nxt;
    ooff_r <= ooff_nxt;
    opg_r  <= opg_nxt;
    olf_r  <= olf_nxt;
  end

  // Output packing
  assign out_tvalid = ov_r;
  assign out_tuser  = ost_r;
  assign out_tdata  = {olf_r, opg_r, ooff_r};

endmodule
`default_nettype wire

>>> tb/buddy_page_allocator_unit_tb.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator_unit_tb: self-checking bench for the buddy allocator
// Drives allocate and free requests on the input stream with bursty timing,
// stalls the result stream, and checks every result against an in-bench
// model of the free-block tree, the granted offset and the rounded size.
// ----------------------------------------------------------------------------
module buddy_page_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpa_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_REQS  = 850;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0]    offset;
    logic [PAGES_W-1:0]  pages;
    logic [VAL_W-1:0]    largest;
  } grant_t;

  typedef struct {
    int unsigned base;
    int unsigned span;
  } block_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow tree of largest free block per node, expected grants
  // --------------------------------------------------------------------------
  class pool_scoreboard;
    logic [VAL_W-1:0] free_run [NODES];
    grant_t           expected_grants[$];
    block_t           live_blocks[$];
    int unsigned      mismatches;

    function new();
      int unsigned span;
      span = 2 * POOL_PAGES;
      for (int i = 0; i < NODES; i++) begin
        if (((i + 1) & i) == 0) span = span >> 1;
        free_run[i] = VAL_W'(span);
      end
      mismatches = 0;
    endfunction

    function int unsigned pow2_ceil(input int unsigned n);
      int unsigned p;
      p = 1;
      while (p < n) p = p << 1;
      return p;
    endfunction

    function logic [VAL_W-1:0] larger(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
      return (a > b) ? a : b;
    endfunction

    // Walk down preferring the left child, mark the node used, refresh parents
    function void grant_block(input int unsigned want, inout grant_t g);
      int unsigned n, idx, span, left;
      if (want == 0) begin
        g.status = ST_BAD_SIZE;
      end else if (want > free_run[0]) begin
        g.status = ST_NO_SPACE;
      end else begin
        n = pow2_ceil(want);
        idx = 0;
        for (span = POOL_PAGES; span > n; span = span >> 1) begin
          left = 2 * idx + 1;
          idx = (free_run[left] >= n) ? left : left + 1;
        end
        free_run[idx] = '0;
        g.status = ST_OK;
        g.offset = OFF_W'((idx + 1) * span - POOL_PAGES);
        g.pages  = PAGES_W'(span);
        while (idx != 0) begin
          idx = (idx + 1) / 2 - 1;
          free_run[idx] = larger(free_run[2*idx+1], free_run[2*idx+2]);
        end
        live_blocks.push_back('{base: (idx == 0) ? int'(g.offset) : 0, span: span});
      end
    endfunction

    // Climb from the leaf to the used node, validate, restore and merge buddies
    function void return_block(input int unsigned want, input int unsigned off,
                               inout grant_t g);
      int unsigned n, idx, span, sum;
      bit hit;
      span = 1;
      hit = 1'b1;
      n = pow2_ceil(want);
      if (want == 0 || n > POOL_PAGES) begin
        g.status = ST_BAD_SIZE;
      end else if (off >= POOL_PAGES) begin
        g.status = ST_BAD_FREE;
      end else begin
        idx = off + POOL_PAGES - 1;
        while (hit && free_run[idx] != 0) begin
          if (idx == 0) begin
            hit = 1'b0;
          end else begin
            span = span << 1;
            idx = (idx + 1) / 2 - 1;
          end
        end
        if (!hit || (off & (span - 1)) != 0) begin
          g.status = ST_BAD_FREE;
        end else if (span != n) begin
          g.status = ST_BAD_SIZE;
        end else begin
          free_run[idx] = VAL_W'(span);
          g.status = ST_OK;
          g.pages  = PAGES_W'(span);
          while (idx != 0) begin
            idx = (idx + 1) / 2 - 1;
            span = span << 1;
            sum = free_run[2*idx+1] + free_run[2*idx+2];
            free_run[idx] = (sum == span) ? VAL_W'(span)
                                          : larger(free_run[2*idx+1], free_run[2*idx+2]);
          end
          foreach (live_blocks[k]) begin
            if (live_blocks[k].base == off) begin
              live_blocks.delete(k);
              break;
            end
          end
        end
      end
    endfunction

    // Accepted request: advance the shadow tree and queue the expected grant
    function void note_request(input logic kind, input logic [PAGES_W-1:0] pages,
                               input logic [OFF_W-1:0] off);
      grant_t g;
      g = '0;
      if (kind == REQ_ALLOC) grant_block(pages, g);
      else return_block(pages, off, g);
      if (g.status != ST_OK) begin
        g.offset = '0;
        g.pages  = '0;
      end
      g.largest = free_run[0];
      expected_grants.push_back(g);
    endfunction

    // Accepted result: compare against the oldest expected grant
    function void check_grant(input logic [STATUS_W-1:0] status,
                              input logic [OUT_TDATA_W-1:0] data);
      grant_t want, got;
      got.status  = status;
      got.offset  = data[OFF_W-1:0];
      got.pages   = data[OFF_W+PAGES_W-1:OFF_W];
      got.largest = data[OFF_W+PAGES_W+VAL_W-1:OFF_W+PAGES_W];
      if (expected_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected result: status=%0d offset=%0d pages=%0d largest=%0d",
                   $realtime, got.status, got.offset, got.pages, got.largest);
        return;
      end
      want = expected_grants.pop_front();
      if (got.status !== want.status || got.offset !== want.offset ||
          got.pages !== want.pages || got.largest !== want.largest) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] mismatch: exp status=%0d offset=%0d pages=%0d largest=%0d, got status=%0d offset=%0d pages=%0d largest=%0d",
                   $realtime, want.status, want.offset, want.pages, want.largest,
                   got.status, got.offset, got.pages, got.largest);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and signals
  // --------------------------------------------------------------------------
  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;  // request_pages, block_offset
  logic                   in_tuser   = 1'b0; // req_type
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // granted_offset, granted_pages, largest_free
  logic [STATUS_W-1:0]    out_tuser;        // status

  pool_scoreboard sb;
  int unsigned    cycles = 0;
  int unsigned    burst_left = 0;

  buddy_page_allocator_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #CLK_HALF clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** buddy_page_allocator_unit: FAILED **");
      $finish;
    end
  end

  // Monitor: note accepted requests and check accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_grant(out_tuser, out_tdata);
      if (in_tvalid && in_tready)
        sb.note_request(in_tuser, in_tdata[PAGES_W-1:0], in_tdata[PAGES_W+OFF_W-1:PAGES_W]);
    end
  end

  // Result backpressure: out_tready follows a 16-bit ready pattern, redrawn from four styles
  logic [15:0] ready_pattern = 16'hFFFF;
  int unsigned pattern_pos   = 0;

  always @(negedge clk) begin
    if (pattern_pos % 64 == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pattern <= 16'hFFFF;
        1: ready_pattern <= 16'($urandom) | 16'h0001;
        2: ready_pattern <= 16'h0001 << $urandom_range(0, 15);
        default: ready_pattern <= 16'($urandom) | 16'($urandom) | 16'h0001;
      endcase
    end
    out_tready  <= ready_pattern[pattern_pos % 16];
    pattern_pos <= pattern_pos + 1;
  end

  // --------------------------------------------------------------------------
  // Driver
  // --------------------------------------------------------------------------
  // Move to the next falling edge, inserting an idle gap at the end of a burst
  task automatic next_slot();
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // Called on a falling edge; holds the request until accepted
  task automatic drive_request(input logic kind, input int unsigned pages,
                               input int unsigned off);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {3'b000, OFF_W'(off), PAGES_W'(pages)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic directed(input logic kind, input int unsigned pages, input int unsigned off);
    next_slot();
    drive_request(kind, pages, off);
  endtask

  // Mostly well-formed allocate/free traffic, the rest malformed
  task automatic random_request();
    int unsigned r, pick;
    block_t b;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 5))
        0: drive_request(REQ_ALLOC, 0, $urandom_range(0, 1023));
        1: drive_request(REQ_FREE, 0, $urandom_range(0, 1023));
        2: drive_request(REQ_ALLOC, $urandom_range(1025, 2047), $urandom_range(0, 1023));
        3: drive_request(REQ_FREE, $urandom_range(1, 2047), $urandom_range(0, 1023));
        default: begin
          if (sb.live_blocks.size() == 0) begin
            drive_request(REQ_FREE, $urandom_range(1, 1024), $urandom_range(0, 1023));
          end else begin
            b = sb.live_blocks[$urandom_range(0, sb.live_blocks.size() - 1)];
            if ($urandom_range(0, 1) == 0 && b.span > 1)
              drive_request(REQ_FREE, b.span, b.base + $urandom_range(1, b.span - 1));
            else
              drive_request(REQ_FREE, $urandom_range(1, 1024), b.base);
          end
        end
      endcase
    end else if (sb.live_blocks.size() != 0 &&
                 r < ((sb.live_blocks.size() > 12 || sb.free_run[0] < 64) ? 70 : 45)) begin
      b = sb.live_blocks[$urandom_range(0, sb.live_blocks.size() - 1)];
      drive_request(REQ_FREE, (b.span == 1) ? 1 : $urandom_range(b.span / 2 + 1, b.span),
                    b.base);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      r = $urandom_range(1, 16);
      else if (pick < 85) r = $urandom_range(17, 128);
      else if (pick < 96) r = $urandom_range(129, 512);
      else                r = $urandom_range(513, 1024);
      drive_request(REQ_ALLOC, r, $urandom_range(0, 1023));
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Size and range corners, then allocation, wrong start, size mismatch, double free
    directed(REQ_ALLOC, 0, 0);
    directed(REQ_FREE, 0, 0);
    directed(REQ_FREE, 1, 1023);
    directed(REQ_FREE, 2047, 0);
    directed(REQ_ALLOC, 2047, 1023);
    directed(REQ_ALLOC, 1024, 0);
    directed(REQ_ALLOC, 1, 0);
    directed(REQ_FREE, 1000, 0);
    directed(REQ_ALLOC, 1, 0);
    directed(REQ_ALLOC, 3, 0);
    directed(REQ_FREE, 4, 5);
    directed(REQ_FREE, 2, 4);
    directed(REQ_FREE, 4, 6);
    directed(REQ_ALLOC, 512, 0);
    directed(REQ_ALLOC, 513, 0);
    directed(REQ_FREE, 512, 512);
    directed(REQ_FREE, 3, 4);
    directed(REQ_FREE, 1, 1);
    directed(REQ_FREE, 1, 0);
    directed(REQ_FREE, 1, 0);
    directed(REQ_ALLOC, 1024, 0);
    directed(REQ_FREE, 1024, 1023);
    directed(REQ_FREE, 1024, 0);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      next_slot();
      random_request();
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("** buddy_page_allocator_unit: PASSED **");
    end else begin
      $display("** buddy_page_allocator_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
sv/bpa_pkg.sv
sv/bpa_ram.sv
sv/bpa_node_unit.sv
sv/buddy_page_allocator_unit.sv
tb/buddy_page_allocator_unit_tb.sv
